FILE: hw/rtl/md5_pkg.sv
// md5_pkg: shared types, constants and round tables for the md5 digest engine
// no dependencies; imported by md5_front, md5_back and the top level
package md5_pkg;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // md5 initial chaining value
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   // pad byte and block geometry
   localparam logic [31:0] PAD_BYTE_WORD = 32'h00000080;
   localparam logic [3:0]  LEN_LO_SLOT   = 4'd14;
   localparam logic [3:0]  LAST_SLOT     = 4'd15;
   localparam logic [5:0]  LAST_ROUND    = 6'd63;
   localparam logic [5:0]  FULL_WORD_BITS = 6'd32;

   // per-round additive constants
   localparam logic [31:0] K_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // back-end sequencer states
   typedef enum logic [4:0] {
      ST_LOAD   = 5'b00001,
      ST_ROUND  = 5'b00010,
      ST_FINISH = 5'b00100,
      ST_PAD    = 5'b01000,
      ST_OUT    = 5'b10000
   } back_state_type;

   // one classified item as it waits in the queue
   typedef struct packed {
      logic [31:0] word;       // message word, already padded if final
      logic        final_word; // last word of the message
      logic        full_pad;   // final word had four bytes: pad byte goes in a word of its own
      logic [5:0]  bit_inc;    // message bits carried by this word
   } md5_entry_type;

   // rotate amount of a round
   function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
      logic [4:0] amt;
      amt = 5'd0;
      unique case ({rnd[5:4], rnd[1:0]})
         4'b0000: amt = 5'd7;
         4'b0001: amt = 5'd12;
         4'b0010: amt = 5'd17;
         4'b0011: amt = 5'd22;
         4'b0100: amt = 5'd5;
         4'b0101: amt = 5'd9;
         4'b0110: amt = 5'd14;
         4'b0111: amt = 5'd20;
         4'b1000: amt = 5'd4;
         4'b1001: amt = 5'd11;
         4'b1010: amt = 5'd16;
         4'b1011: amt = 5'd23;
         4'b1100: amt = 5'd6;
         4'b1101: amt = 5'd10;
         4'b1110: amt = 5'd15;
         4'b1111: amt = 5'd21;
         default: amt = 5'd0;
      endcase
      return amt;
   endfunction

   // message word used by a round
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] j;
      logic [3:0] idx;
      j   = rnd[3:0];
      idx = j;
      unique case (rnd[5:4])
         2'd0:    idx = j;
         2'd1:    idx = 4'd1 + {j[1:0], 2'b00} + j;
         2'd2:    idx = 4'd5 + {j[2:0], 1'b0} + j;
         2'd3:    idx = {j[0], 3'b000} - j;
         default: idx = j;
      endcase
      return idx;
   endfunction

   // round function by phase
   function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      f = '0;
      unique case (phase)
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (b & d) | (c & ~d);
         2'd2:    f = b ^ c ^ d;
         2'd3:    f = c ^ (b | ~d);
         default: f = '0;
      endcase
      return f;
   endfunction

endpackage

FILE: hw/rtl/md5_req_if.sv
// md5_req_if: valid/ready channel for message words into the digest engine
// depends on nothing but the port widths of the message word item
interface md5_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  byte_count;
   logic        final_word;

   modport source (output valid, output message_word, output byte_count,
                   output final_word, input ready);
   modport sink   (input valid, input message_word, input byte_count,
                   input final_word, output ready);
endinterface

FILE: hw/rtl/md5_rsp_if.sv
// md5_rsp_if: valid/ready channel for digest words out of the digest engine
// depends on nothing but the port widths of the digest word item
interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        digest_last;

   modport source (output valid, output digest_word, output word_index,
                   output digest_last, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input digest_last, output ready);
endinterface

FILE: hw/rtl/md5_front.sv
// md5_front: accepts message words, masks and pads the final word, queues items
// depends on md5_pkg and md5_req_if
module md5_front
   import md5_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   md5_req_if.sink       req_chan,
   output logic          entry_valid,
   output md5_entry_type entry,
   input  logic          entry_ready
);

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   md5_entry_type queue_mem [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   logic          push;
   logic          pop;
   logic [2:0]    count_sat;
   logic [31:0]   padded;
   md5_entry_type classified;

   // classify the incoming item
   always_comb begin
      count_sat = (req_chan.byte_count > 3'd4) ? 3'd4 : req_chan.byte_count;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < count_sat) begin
            padded[i*8 +: 8] = req_chan.message_word[i*8 +: 8];
         end else if (3'(i) == count_sat) begin
            padded[i*8 +: 8] = PAD_BYTE_WORD[7:0];
         end else begin
            padded[i*8 +: 8] = 8'h00;
         end
      end
      classified.final_word = req_chan.final_word;
      classified.word       = req_chan.final_word ? padded : req_chan.message_word;
      classified.full_pad   = req_chan.final_word && (count_sat == 3'd4);
      classified.bit_inc    = req_chan.final_word ? {count_sat, 3'b000} : FULL_WORD_BITS;
   end

   // queue control
   assign req_chan.ready = (count_ff != CntW'(QueueDepth));
   assign push           = req_chan.valid && req_chan.ready;
   assign entry_valid    = (count_ff != '0);
   assign pop            = entry_valid && entry_ready;
   assign entry          = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= classified;
      end
   end

endmodule

FILE: hw/rtl/md5_back.sv
// md5_back: block store, padding sequencer, one-round-per-cycle md5 core, digest output
// depends on md5_pkg and md5_rsp_if
module md5_back
   import md5_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          entry_valid,
   input  md5_entry_type entry,
   output logic          entry_ready,
   md5_rsp_if.source     rsp_chan
);

   back_state_type state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic        pad_mode_ff, pad_mode_in;
   logic        pend80_ff, pend80_in;
   logic        lo_done_ff, lo_done_in;
   logic        last_blk_ff, last_blk_in;
   logic [5:0]  round_ff, round_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [31:0] pre_ff, pre_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [1:0]  idx_ff, idx_in;

   logic [31:0] block_mem [16];

   logic        pop;
   logic        push_en;
   logic [31:0] push_data;
   logic        block_full;
   logic [31:0] f_val;
   logic [31:0] sum;
   logic [63:0] rot64;
   logic [31:0] new_b;
   logic [5:0]  next_round;
   logic [31:0] pre_next;
   logic [31:0] pre_start;
   logic        rsp_take;

   assign entry_ready = (state_ff == ST_LOAD);
   assign pop         = entry_valid && entry_ready;

   // word written into the block this cycle
   always_comb begin
      push_en   = 1'b0;
      push_data = entry.word;
      if (state_ff == ST_LOAD) begin
         push_en = pop;
      end else if (state_ff == ST_PAD) begin
         push_en = 1'b1;
         if (pend80_ff) begin
            push_data = PAD_BYTE_WORD;
         end else if (cnt_ff == LEN_LO_SLOT) begin
            push_data = bitlen_ff[31:0];
         end else if ((cnt_ff == LAST_SLOT) && lo_done_ff) begin
            push_data = bitlen_ff[63:32];
         end else begin
            push_data = '0;
         end
      end
   end
   assign block_full = push_en && (cnt_ff == LAST_SLOT);

   // round datapath
   assign f_val      = round_f(round_ff[5:4], b_ff, c_ff, d_ff);
   assign sum        = pre_ff + f_val;
   assign rot64      = {sum, sum} << rot_amount(round_ff);
   assign new_b      = b_ff + rot64[63:32];
   assign next_round = round_ff + 1'b1;
   assign pre_next   = d_ff + block_mem[msg_index(next_round)] + K_TABLE[next_round];
   assign pre_start  = chain_ff[0] + block_mem[0] + K_TABLE[0];

   // digest output
   assign rsp_chan.valid       = (state_ff == ST_OUT);
   assign rsp_chan.digest_word = chain_ff[idx_ff];
   assign rsp_chan.word_index  = idx_ff;
   assign rsp_chan.digest_last = (idx_ff == 2'd3);
   assign rsp_take             = rsp_chan.valid && rsp_chan.ready;

   // sequencer next state
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      bitlen_in   = bitlen_ff;
      pad_mode_in = pad_mode_ff;
      pend80_in   = pend80_ff;
      lo_done_in  = lo_done_ff;
      last_blk_in = last_blk_ff;
      round_in    = round_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      d_in        = d_ff;
      pre_in      = pre_ff;
      idx_in      = idx_ff;
      for (int k = 0; k < 4; k++) begin
         chain_in[k] = chain_ff[k];
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               bitlen_in = bitlen_ff + 64'(entry.bit_inc);
               if (entry.final_word) begin
                  pad_mode_in = 1'b1;
                  pend80_in   = entry.full_pad;
                  state_in    = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (pend80_ff) begin
               pend80_in = 1'b0;
            end else if (cnt_ff == LEN_LO_SLOT) begin
               lo_done_in = 1'b1;
            end else if ((cnt_ff == LAST_SLOT) && lo_done_ff) begin
               last_blk_in = 1'b1;
            end
         end
         ST_ROUND: begin
            a_in     = d_ff;
            d_in     = c_ff;
            c_in     = b_ff;
            b_in     = new_b;
            pre_in   = pre_next;
            round_in = next_round;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            if (last_blk_ff) begin
               state_in = ST_OUT;
            end else if (pad_mode_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_OUT: begin
            if (rsp_take) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 2'd3) begin
                  chain_in[0] = IV_A;
                  chain_in[1] = IV_B;
                  chain_in[2] = IV_C;
                  chain_in[3] = IV_D;
                  bitlen_in   = '0;
                  cnt_in      = '0;
                  pad_mode_in = 1'b0;
                  pend80_in   = 1'b0;
                  lo_done_in  = 1'b0;
                  last_blk_in = 1'b0;
                  state_in    = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase

      // block slot advance and start of compression
      if (push_en) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (block_full) begin
         state_in = ST_ROUND;
         round_in = '0;
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         pre_in   = pre_start;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         cnt_ff      <= '0;
         bitlen_ff   <= '0;
         pad_mode_ff <= 1'b0;
         pend80_ff   <= 1'b0;
         lo_done_ff  <= 1'b0;
         last_blk_ff <= 1'b0;
         round_ff    <= '0;
         idx_ff      <= '0;
         chain_ff[0] <= IV_A;
         chain_ff[1] <= IV_B;
         chain_ff[2] <= IV_C;
         chain_ff[3] <= IV_D;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         bitlen_ff   <= bitlen_in;
         pad_mode_ff <= pad_mode_in;
         pend80_ff   <= pend80_in;
         lo_done_ff  <= lo_done_in;
         last_blk_ff <= last_blk_in;
         round_ff    <= round_in;
         idx_ff      <= idx_in;
         for (int k = 0; k < 4; k++) begin
            chain_ff[k] <= chain_in[k];
         end
      end
   end

   // working variables, no reset
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      pre_ff <= pre_in;
   end

   // block store
   always_ff @(posedge clock) begin
      if (push_en) begin
         block_mem[cnt_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/md5_digest_engine_unit.sv
// md5_digest_engine_unit: top level of the md5 digest engine
// depends on md5_pkg, md5_req_if, md5_rsp_if, md5_front and md5_back
//
//   channel    direction  item
//   req_chan   in         message_word[31:0], byte_count[2:0], final_word
//   rsp_chan   out        digest_word[31:0], word_index[1:0], digest_last
//
// each word is written into the block store; every full 16-word block then runs
// through the round unit (one round a cycle) and is folded into the chaining value.
// a final word adds one or two padded blocks, then four digest words, one per cycle
// while the output is ready.
// reset is synchronous and restores the initial chaining value and an empty message.
// the front queue keeps taking words until it is full while the round unit or a stalled output holds the back.
module md5_digest_engine_unit
   import md5_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   md5_req_if.sink   req_chan,
   md5_rsp_if.source rsp_chan
);

   logic          entry_valid;
   logic          entry_ready;
   md5_entry_type entry;

   // accept and classify
   md5_front #(
      .QueueDepth (QueueDepth)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .entry_valid (entry_valid),
      .entry       (entry),
      .entry_ready (entry_ready)
   );

   // hash and emit
   md5_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (entry_valid),
      .entry       (entry),
      .entry_ready (entry_ready),
      .rsp_chan    (rsp_chan)
   );

`ifndef SYNTH
   // last flag only on the fourth digest word
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.digest_last |-> rsp_chan.word_index == 2'd3)
      else $error("digest_last on a word other than the fourth");

   // digest words go out in order without gaps
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.digest_last
      |=> rsp_chan.valid && rsp_chan.word_index == $past(rsp_chan.word_index) + 2'd1)
      else $error("digest word sequence broken");

   // a digest starts at word A
   a_first_index: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> rsp_chan.word_index == 2'd0)
      else $error("digest does not start at word A");
`endif

endmodule
